// File: sv/actd_pkg.sv
// Shared constants, types and fixed-point helpers of the TD update unit.
package actd_pkg;

  localparam int STATES            = 256;
  localparam int STATE_W           = $clog2(STATES);
  localparam int ACTUATORS         = 2;
  localparam int ACT_W             = (ACTUATORS > 1) ? $clog2(ACTUATORS) : 1;
  localparam int MEM_AW            = ACT_W + STATE_W;
  localparam int MEM_DEPTH         = (1 << ACT_W) * STATES;
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int EXP_IDX_W         = $clog2(EXP_TABLE_ENTRIES);
  localparam int CFG_W             = 17;
  localparam int DIV_STEPS         = 48;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS);
  localparam int LOG2E_Q16         = 94548;
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam logic [30:0] SIGMA_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] SIGMA_MIN = 31'd65536;

  typedef enum logic [1:0] {
    REG_DISCOUNT  = 2'd0,
    REG_VALUE_LR  = 2'd1,
    REG_POLICY_LR = 2'd2,
    REG_INIT_DEV  = 2'd3
  } reg_idx_e;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_RDV, ST_MDISC, ST_DELTA, ST_MVLR, ST_VUPD, ST_MG, ST_G,
    ST_RDP, ST_CAPP, ST_MT, ST_FRAC, ST_MI, ST_VAL, ST_MP, ST_SIG, ST_DIFF1, ST_MM,
    ST_MEAN, ST_DIFF2, ST_DSTART, ST_DWAIT, ST_Q, ST_MQ, ST_SQ, ST_ML, ST_LD,
    ST_RDO, ST_CAPO, ST_OSIG, ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_MDISC, OP_DELTA, OP_MVLR, OP_VUPD, OP_MG, OP_G,
    OP_CAPP, OP_MT, OP_FRAC, OP_MI, OP_VAL, OP_MP, OP_SIG, OP_DIFF, OP_MM, OP_MEAN,
    OP_DSTART, OP_Q, OP_MQ, OP_SQ, OP_ML, OP_LD, OP_RDO, OP_CAPO, OP_OSIG, OP_DONE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ACT_W-1:0] act;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic out_busy;
  } stat_t;

  typedef logic [31:0] exp_tab_t [EXP_TABLE_ENTRIES+1];

  function automatic logic signed [65:0] ext66(input logic signed [31:0] x);
    return {{34{x[31]}}, x};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x,
                                               output logic hit);
    logic signed [31:0] r;
    hit = 1'b0;
    r   = x[31:0];
    if (x > 66'sd2147483647) begin
      hit = 1'b1;
      r   = 32'sh7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      hit = 1'b1;
      r   = 32'sh8000_0000;
    end
    return r;
  endfunction

  // Round to nearest (ties up) and drop 16 fraction bits.
  function automatic logic signed [31:0] qmul(input logic signed [65:0] p,
                                              output logic hit);
    logic signed [65:0] r;
    r = (p + 66'sd32768) >>> 16;
    return sat32(r, hit);
  endfunction

  function automatic logic [63:0] div_small(input logic [63:0] x, input int n);
    logic [63:0] r;
    case (n)
      1:  r = x;
      2:  r = x / 2;
      3:  r = x / 3;
      4:  r = x / 4;
      5:  r = x / 5;
      6:  r = x / 6;
      7:  r = x / 7;
      8:  r = x / 8;
      9:  r = x / 9;
      10: r = x / 10;
      11: r = x / 11;
      12: r = x / 12;
      13: r = x / 13;
      14: r = x / 14;
      15: r = x / 15;
      16: r = x / 16;
      17: r = x / 17;
      18: r = x / 18;
      19: r = x / 19;
      20: r = x / 20;
      default: r = x;
    endcase
    return r;
  endfunction

  // 2^(j/N) in Q2.30 from the series of exp(j*ln2/N) up to its 20th-order term.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    for (int j = 0; j <= EXP_TABLE_ENTRIES; j++) begin
      y    = (LN2_Q30 * 64'(j) + 64'(EXP_TABLE_ENTRIES / 2)) / EXP_TABLE_ENTRIES;
      term = 64'd1 << 30;
      sum  = term;
      for (int n = 1; n <= 20; n++) begin
        term = div_small((term * y + (64'd1 << 29)) >> 30, n);
        sum  = sum + term;
      end
      tab[j] = sum[31:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// File: sv/actd_div.sv
// Restoring divider, one quotient bit per cycle, for (|diff| << 16) / sigma.
module actd_div
  import actd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [30:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]          rem_q, rem_d;
  logic [47:0]          quo_q, quo_d;
  logic [30:0]          dvs_q, dvs_d;
  logic [32:0]          rem_sh;

  assign done_o     = busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign quotient_o = quo_q[31:0];

  always_comb begin
    rem_sh = {rem_q, quo_q[47]};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = {dividend_i, 16'b0};
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {2'b0, dvs_q}) begin
        rem_d = 32'(rem_sh - {2'b0, dvs_q});
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

// File: sv/actd_ctrl.sv
// Sequencer of the TD update: steps the shared datapath through one word.
module actd_ctrl
  import actd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e           state_q, state_d;
  logic [ACT_W-1:0] act_q, act_d;
  logic             phase_q, phase_d;
  logic             act_last;

  assign act_last   = (act_q == ACT_W'(ACTUATORS - 1));
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    phase_d = phase_q;
    unique case (state_q)
      ST_CLEAR:  if (stat_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RDV;
          act_d   = '0;
          phase_d = 1'b0;
        end
      end
      ST_RDV:    state_d = ST_MDISC;
      ST_MDISC:  state_d = ST_DELTA;
      ST_DELTA:  state_d = ST_MVLR;
      ST_MVLR:   state_d = ST_VUPD;
      ST_VUPD:   state_d = ST_MG;
      ST_MG:     state_d = ST_G;
      ST_G:      state_d = ST_RDP;
      ST_RDP:    state_d = ST_CAPP;
      ST_CAPP:   state_d = ST_MT;
      ST_MT:     state_d = ST_FRAC;
      ST_FRAC:   state_d = ST_MI;
      ST_MI:     state_d = ST_VAL;
      ST_VAL:    state_d = ST_MP;
      ST_MP:     state_d = ST_SIG;
      ST_SIG:    state_d = phase_q ? ST_OSIG : ST_DIFF1;
      ST_DIFF1:  state_d = ST_MM;
      ST_MM:     state_d = ST_MEAN;
      ST_MEAN:   state_d = ST_DIFF2;
      ST_DIFF2:  state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT:  if (stat_i.div_done) state_d = ST_Q;
      ST_Q:      state_d = ST_MQ;
      ST_MQ:     state_d = ST_SQ;
      ST_SQ:     state_d = ST_ML;
      ST_ML:     state_d = ST_LD;
      ST_LD: begin
        if (act_last) begin
          state_d = ST_RDO;
          act_d   = '0;
          phase_d = 1'b1;
        end else begin
          state_d = ST_RDP;
          act_d   = act_q + 1'b1;
        end
      end
      ST_RDO:    state_d = ST_CAPO;
      ST_CAPO:   state_d = ST_MT;
      ST_OSIG: begin
        if (act_last) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RDO;
          act_d   = act_q + 1'b1;
        end
      end
      ST_DONE:   if (!stat_i.out_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.act = act_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      ST_CLEAR:  cmd_o.op = OP_CLEAR;
      ST_IDLE:   cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      ST_MDISC:  cmd_o.op = OP_MDISC;
      ST_DELTA:  cmd_o.op = OP_DELTA;
      ST_MVLR:   cmd_o.op = OP_MVLR;
      ST_VUPD:   cmd_o.op = OP_VUPD;
      ST_MG:     cmd_o.op = OP_MG;
      ST_G:      cmd_o.op = OP_G;
      ST_CAPP:   cmd_o.op = OP_CAPP;
      ST_MT:     cmd_o.op = OP_MT;
      ST_FRAC:   cmd_o.op = OP_FRAC;
      ST_MI:     cmd_o.op = OP_MI;
      ST_VAL:    cmd_o.op = OP_VAL;
      ST_MP:     cmd_o.op = OP_MP;
      ST_SIG:    cmd_o.op = OP_SIG;
      ST_DIFF1:  cmd_o.op = OP_DIFF;
      ST_MM:     cmd_o.op = OP_MM;
      ST_MEAN:   cmd_o.op = OP_MEAN;
      ST_DIFF2:  cmd_o.op = OP_DIFF;
      ST_DSTART: cmd_o.op = OP_DSTART;
      ST_Q:      cmd_o.op = OP_Q;
      ST_MQ:     cmd_o.op = OP_MQ;
      ST_SQ:     cmd_o.op = OP_SQ;
      ST_ML:     cmd_o.op = OP_ML;
      ST_LD:     cmd_o.op = OP_LD;
      ST_RDO:    cmd_o.op = OP_RDO;
      ST_CAPO:   cmd_o.op = OP_CAPO;
      ST_OSIG:   cmd_o.op = OP_OSIG;
      ST_DONE:   cmd_o.op = stat_i.out_busy ? OP_NONE : OP_DONE;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      act_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      phase_q <= phase_d;
    end
  end

endmodule

// File: sv/actd_dpath.sv
// Datapath: tables, shared multiplier, sigma unit, divider and result register.
module actd_dpath
  import actd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic [7:0]         new_state_i,
  input  logic signed [15:0] reward_i,
  input  logic signed [31:0] taken_action_a_i,
  input  logic signed [31:0] taken_action_b_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] td_error_o,
  output logic signed [31:0] mean_a_o,
  output logic signed [31:0] mean_b_o,
  output logic [30:0]        deviation_a_o,
  output logic [30:0]        deviation_b_o,
  output logic               saturated_o
);

  // configuration and control state
  logic [CFG_W-1:0]   disc_q, vlr_q, plr_q;
  logic [15:0]        idev_q;
  logic [STATE_W-1:0] prev_q;
  logic [MEM_AW-1:0]  clr_cnt_q;
  logic               out_valid_q;

  // tables
  logic signed [31:0] vmem [STATES];
  logic signed [31:0] mmem [MEM_DEPTH];
  logic signed [31:0] lmem [MEM_DEPTH];
  logic signed [31:0] vrd0_q, vrd1_q, mrd_q, lrd_q;
  logic [MEM_AW-1:0]  m_addr;
  logic               v_we, m_we, l_we;
  logic [STATE_W-1:0] v_wa;

  // item registers
  logic [STATE_W-1:0]   ns_q;
  logic signed [15:0]   reward_q;
  logic signed [31:0]   acta_q, actb_q;
  logic signed [31:0]   vp_q, delta_q, g_q, mean_q, sld_q, diff_q, q_q, term_q;
  logic signed [65:0]   pr_q;
  logic signed [17:0]   k_q;
  logic [EXP_IDX_W-1:0] idx_q;
  logic [15:0]          fr_q;
  logic [31:0]          lo_q, val_q;
  logic [30:0]          sig_q;
  logic                 sat_q, sat_d;
  logic signed [31:0]   omean_q [2];
  logic [30:0]          odev_q [2];
  logic signed [31:0]   td_q, oma_q, omb_q;
  logic [30:0]          oda_q, odb_q;
  logic                 osat_q;

  // combinational results
  logic signed [32:0]   mul_a, mul_b;
  logic signed [31:0]   qres, delta_c, add_c, diff_c, q_c, act_sel, add_base;
  logic                 hq, hd1, ha, hdf, hqc, hs;
  logic [EXP_IDX_W:0]   idx_lo, idx_hi;
  logic [31:0]          tab_lo, tab_hi;
  logic signed [65:0]   val_rnd;
  logic [31:0]          mag;
  logic signed [33:0]   q_signed;
  logic [31:0]          quo;
  logic                 div_done;

  // sigma unit
  logic [47:0]          prod;
  logic signed [18:0]   s_amt, s_neg;
  logic [5:0]           sh;
  logic [48:0]          rnd, shr;
  logic [63:0]          shl;
  logic [30:0]          sig_c;

  assign stat_o.clr_last = (clr_cnt_q == '1);
  assign stat_o.div_done = div_done;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign act_sel = cmd_i.act[0] ? actb_q : acta_q;
  assign idx_lo  = {1'b0, idx_q};
  assign idx_hi  = idx_lo + 1'b1;
  assign tab_lo  = EXP_TAB[idx_lo];
  assign tab_hi  = EXP_TAB[idx_hi];
  assign mag     = diff_q[31] ? 32'(-diff_q) : diff_q;

  actd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DSTART),
    .dividend_i (mag),
    .divisor_i  (sig_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_MDISC: begin
        mul_a = $signed({16'b0, disc_q});
        mul_b = {vrd0_q[31], vrd0_q};
      end
      OP_MVLR: begin
        mul_a = $signed({16'b0, vlr_q});
        mul_b = {delta_q[31], delta_q};
      end
      OP_MG: begin
        mul_a = $signed({16'b0, plr_q});
        mul_b = {delta_q[31], delta_q};
      end
      OP_MT: begin
        mul_a = {sld_q[31], sld_q};
        mul_b = 33'(LOG2E_Q16);
      end
      OP_MI: begin
        mul_a = $signed({1'b0, 32'(tab_hi - tab_lo)});
        mul_b = $signed({17'b0, fr_q});
      end
      OP_MP: begin
        mul_a = $signed({17'b0, idev_q});
        mul_b = $signed({1'b0, val_q});
      end
      OP_MM: begin
        mul_a = {g_q[31], g_q};
        mul_b = {diff_q[31], diff_q};
      end
      OP_MQ: begin
        mul_a = {q_q[31], q_q};
        mul_b = {q_q[31], q_q};
      end
      OP_ML: begin
        mul_a = {g_q[31], g_q};
        mul_b = {term_q[31], term_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // arithmetic on the registered product
  always_comb begin
    qres    = qmul(pr_q, hq);
    delta_c = sat32({{34{reward_q[15]}}, reward_q, 16'b0} + ext66(qres) - ext66(vp_q), hd1);
    case (cmd_i.op)
      OP_VUPD: add_base = vp_q;
      OP_MEAN: add_base = mean_q;
      OP_LD:   add_base = sld_q;
      OP_SQ:   add_base = -32'sd65536;
      default: add_base = '0;
    endcase
    add_c    = sat32(ext66(add_base) + ext66(qres), ha);
    diff_c   = sat32(ext66(act_sel) - ext66(mean_q), hdf);
    q_signed = diff_q[31] ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
    q_c      = sat32({{32{q_signed[33]}}, q_signed}, hqc);
    val_rnd  = pr_q + 66'sd32768;
  end

  // sigma = max(1, initial * 2^k * table), saturated at SIGMA_MAX, from the product and exponent
  always_comb begin
    prod  = pr_q[47:0];
    s_amt = 19'sd14 - {k_q[17], k_q};
    s_neg = 19'sd0 - s_amt;
    sh    = (s_amt > 19'sd48) ? 6'd48 : s_amt[5:0];
    rnd   = (49'd1 << sh) >> 1;
    shr   = ({1'b0, prod} + rnd) >> sh;
    shl   = {16'b0, prod} << s_neg[4:0];
    hs    = 1'b0;
    sig_c = '0;
    if (prod == '0) begin
      sig_c = '0;
    end else if (s_amt >= 19'sd0) begin
      if (shr > {18'b0, SIGMA_MAX}) begin
        hs    = 1'b1;
        sig_c = SIGMA_MAX;
      end else begin
        sig_c = shr[30:0];
      end
    end else if (s_amt < -19'sd16) begin
      hs    = 1'b1;
      sig_c = SIGMA_MAX;
    end else if (shl > {33'b0, SIGMA_MAX}) begin
      hs    = 1'b1;
      sig_c = SIGMA_MAX;
    end else begin
      sig_c = shl[30:0];
    end
    if (sig_c < SIGMA_MIN) begin
      sig_c = SIGMA_MIN;
    end
  end

  always_comb begin
    sat_d = sat_q;
    case (cmd_i.op)
      OP_DELTA:                         sat_d = sat_q | hq | hd1;
      OP_VUPD, OP_G, OP_MEAN, OP_SQ,
      OP_LD:                            sat_d = sat_q | hq | ha;
      OP_DIFF:                          sat_d = sat_q | hdf;
      OP_Q:                             sat_d = sat_q | hqc;
      OP_SIG:                           sat_d = sat_q | hs;
      default:                          sat_d = sat_q;
    endcase
  end

  // table access
  always_comb begin
    case (cmd_i.op)
      OP_CLEAR: m_addr = clr_cnt_q;
      OP_RDO:   m_addr = {cmd_i.act, ns_q};
      default:  m_addr = {cmd_i.act, prev_q};
    endcase
    v_we = (cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_VUPD);
    m_we = (cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_MEAN);
    l_we = (cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_LD);
    v_wa = (cmd_i.op == OP_CLEAR) ? clr_cnt_q[STATE_W-1:0] : prev_q;
  end

  always_ff @(posedge clk_i) begin
    vrd0_q <= vmem[ns_q];
    vrd1_q <= vmem[prev_q];
    if (v_we) begin
      vmem[v_wa] <= (cmd_i.op == OP_CLEAR) ? '0 : add_c;
    end
  end

  always_ff @(posedge clk_i) begin
    mrd_q <= mmem[m_addr];
    if (m_we) begin
      mmem[m_addr] <= (cmd_i.op == OP_CLEAR) ? '0 : add_c;
    end
  end

  always_ff @(posedge clk_i) begin
    lrd_q <= lmem[m_addr];
    if (l_we) begin
      lmem[m_addr] <= (cmd_i.op == OP_CLEAR) ? '0 : add_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_q      <= CFG_W'(32768);
      vlr_q       <= CFG_W'(9830);
      plr_q       <= CFG_W'(655);
      idev_q      <= 16'd100;
      prev_q      <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DISCOUNT:  disc_q <= cfg_data_i;
          REG_VALUE_LR:  vlr_q  <= cfg_data_i;
          REG_POLICY_LR: plr_q  <= cfg_data_i;
          REG_INIT_DEV:  idev_q <= cfg_data_i[15:0];
          default:       idev_q <= idev_q;
        endcase
      end
      if (cmd_i.op == OP_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.op == OP_DONE) begin
        prev_q      <= ns_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q  <= mul_a * mul_b;
    sat_q <= (cmd_i.op == OP_LOAD) ? 1'b0 : sat_d;
    case (cmd_i.op)
      OP_LOAD: begin
        ns_q     <= new_state_i;
        reward_q <= reward_i;
        acta_q   <= taken_action_a_i;
        actb_q   <= taken_action_b_i;
      end
      OP_MDISC: vp_q    <= vrd1_q;
      OP_DELTA: delta_q <= delta_c;
      OP_G:     g_q     <= add_c;
      OP_CAPP: begin
        mean_q <= mrd_q;
        sld_q  <= lrd_q;
      end
      OP_FRAC: begin
        k_q   <= pr_q[49:32];
        idx_q <= pr_q[31 -: EXP_IDX_W];
        fr_q  <= pr_q[31-EXP_IDX_W -: 16];
      end
      OP_MI:    lo_q   <= tab_lo;
      OP_VAL:   val_q  <= lo_q + val_rnd[47:16];
      OP_SIG:   sig_q  <= sig_c;
      OP_DIFF:  diff_q <= diff_c;
      OP_MEAN:  mean_q <= add_c;
      OP_Q:     q_q    <= q_c;
      OP_SQ:    term_q <= add_c;
      OP_CAPO: begin
        omean_q[cmd_i.act] <= mrd_q;
        sld_q              <= lrd_q;
      end
      OP_OSIG:  odev_q[cmd_i.act] <= sig_q;
      OP_DONE: begin
        td_q   <= delta_q;
        oma_q  <= omean_q[0];
        omb_q  <= (ACTUATORS > 1) ? omean_q[1] : '0;
        oda_q  <= odev_q[0];
        odb_q  <= (ACTUATORS > 1) ? odev_q[1] : '0;
        osat_q <= sat_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign td_error_o    = td_q;
  assign mean_a_o      = oma_q;
  assign mean_b_o      = omb_q;
  assign deviation_a_o = oda_q;
  assign deviation_b_o = odb_q;
  assign saturated_o   = osat_q;

endmodule

// File: sv/actor_critic_td_update_unit.sv
// Top level of the actor-critic TD(0) update unit.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/ready_o   | new_state, reward, taken_action_a/b
//   out     | output    | out_valid_o/ready_i  | td_error, mean_a/b, deviation_a/b, saturated
//   cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// The bit-serial divide per actuator takes most of the time of one word; the rest
// is the shared multiplier stepping through the update and sigma.
// After reset a clearing pass zeroes the tables; no word is taken meanwhile.
// A finished result waits in the output register; the next word is taken while it waits.
// A stalled output holds the unit only when a second result is ready to replace it.
module actor_critic_td_update_unit
  import actd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         new_state_i,
  input  logic signed [15:0] reward_i,
  input  logic signed [31:0] taken_action_a_i,
  input  logic signed [31:0] taken_action_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] td_error_o,
  output logic signed [31:0] mean_a_o,
  output logic signed [31:0] mean_b_o,
  output logic [30:0]        deviation_a_o,
  output logic [30:0]        deviation_b_o,
  output logic               saturated_o
);

  cmd_t  cmd;
  stat_t stat;

  actd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  actd_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .new_state_i      (new_state_i),
    .reward_i         (reward_i),
    .taken_action_a_i (taken_action_a_i),
    .taken_action_b_i (taken_action_b_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .td_error_o       (td_error_o),
    .mean_a_o         (mean_a_o),
    .mean_b_o         (mean_b_o),
    .deviation_a_o    (deviation_a_o),
    .deviation_b_o    (deviation_b_o),
    .saturated_o      (saturated_o)
  );

endmodule

// File: sv/actd_checker.sv
// Port-level checks of the TD update unit, bound to the top level.
module actd_checker
  import actd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] td_error_o,
  input logic signed [31:0] mean_a_o,
  input logic signed [31:0] mean_b_o,
  input logic [30:0]        deviation_a_o,
  input logic [30:0]        deviation_b_o,
  input logic               saturated_o
);

  // a taken word keeps the unit busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(td_error_o)
      && $stable(mean_a_o) && $stable(mean_b_o) && $stable(deviation_a_o)
      && $stable(deviation_b_o) && $stable(saturated_o))
    else $error("stalled result changed");

  a_dev_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> deviation_a_o >= SIGMA_MIN
      && (ACTUATORS < 2 || deviation_b_o >= SIGMA_MIN))
    else $error("deviation below one");

endmodule

bind actor_critic_td_update_unit actd_checker u_actd_checker (.*);
